// ===== rtl/cursor_line_editor_assert.svh =====
// Assertion macros for the cursor line editor checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef CURSOR_LINE_EDITOR_ASSERT_SVH
`define CURSOR_LINE_EDITOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define CLE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cursor_line_editor: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define CLE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cursor_line_editor: assertion failed");

`endif

// ===== rtl/cle_pkg.sv =====
// Shared types and constants of the cursor line editor.
// Depends on nothing; used by the top level and the sequencer.
package cle_pkg;

    localparam int LINE_DEPTH = 64;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
    localparam int CHAR_W     = 8;

    localparam logic [CHAR_W-1:0] KEY_LEFT  = 8'h3C;
    localparam logic [CHAR_W-1:0] KEY_RIGHT = 8'h3E;
    localparam logic [CHAR_W-1:0] KEY_DEL   = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOVE_L,
        ST_MOVE_R,
        ST_WALK,
        ST_EMPTY
    } t_state;

    // One access request to a stack memory
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // One result item of a finished line
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last_char;
        logic              line_empty;
        logic              overflowed;
    } t_result;

endpackage

// ===== rtl/cle_if.sv =====
// Valid/ready channel interfaces for keystrokes in and line characters out.
// Depends on nothing.
interface cle_key_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] key_code;

    modport source (output valid, output func, output key_code, input ready);
    modport sink   (input valid, input func, input key_code, output ready);
endinterface

interface cle_line_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;
    logic       line_empty;
    logic       overflowed;

    modport source (output valid, output out_char, output last_char,
                    output line_empty, output overflowed, input ready);
    modport sink   (input valid, input out_char, input last_char,
                    input line_empty, input overflowed, output ready);
endinterface

// ===== rtl/cursor_line_editor.sv =====
// Keystrokes: insert, delete or no-op finish in the idle state; a cursor move reads in
// the idle state and writes in a move state. Finish: the first character passes the
// stack read register and the output register, then the rest follow one per cycle while
// the sink is ready; an empty line gives its single result through the empty state.
// Synchronous active-low reset clears counts, overflow flag and output valid;
// the stack memories are not cleared and need no clearing pass.
//
// Top level of the cursor line editor: two stack memories, sequencer and the
// output register. Depends on cle_pkg, cle_if, cle_stack_ram and cle_ctrl.
module cursor_line_editor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cle_key_if.sink    i_key,
    cle_line_if.source o_line
);

    cle_pkg::t_ram_req               left_req;
    cle_pkg::t_ram_req               right_req;
    logic [cle_pkg::CHAR_W-1:0]      left_rdata;
    logic [cle_pkg::CHAR_W-1:0]      right_rdata;
    logic                            res_valid;
    logic                            res_ready;
    cle_pkg::t_result                res;

    logic                            r_out_valid;
    cle_pkg::t_result                r_out;

    cle_stack_ram #(
        .DEPTH (cle_pkg::LINE_DEPTH),
        .WIDTH (cle_pkg::CHAR_W)
    ) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (left_req.we),
        .i_waddr (left_req.waddr),
        .i_wdata (left_req.wdata),
        .i_re    (left_req.re),
        .i_raddr (left_req.raddr),
        .o_rdata (left_rdata)
    );

    cle_stack_ram #(
        .DEPTH (cle_pkg::LINE_DEPTH),
        .WIDTH (cle_pkg::CHAR_W)
    ) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (right_req.we),
        .i_waddr (right_req.waddr),
        .i_wdata (right_req.wdata),
        .i_re    (right_req.re),
        .i_raddr (right_req.raddr),
        .o_rdata (right_rdata)
    );

    cle_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key         (i_key),
        .i_left_rdata  (left_rdata),
        .i_right_rdata (right_rdata),
        .o_left_req    (left_req),
        .o_right_req   (right_req),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    // Output register: take a new result when empty or being drained
    assign res_ready = !r_out_valid || o_line.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_line.valid      = r_out_valid;
    assign o_line.out_char   = r_out.out_char;
    assign o_line.last_char  = r_out.last_char;
    assign o_line.line_empty = r_out.line_empty;
    assign o_line.overflowed = r_out.overflowed;

endmodule

// ===== rtl/cle_stack_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; holds one stack of the line editor.
module cle_stack_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port: data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cle_ctrl.sv =====
// Sequencer of the line editor: keystroke read-modify-write and line walk.
// Depends on cle_pkg and cle_key_if; drives both stack memories.
module cle_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    cle_key_if.sink                      i_key,
    input  logic [cle_pkg::CHAR_W-1:0]   i_left_rdata,
    input  logic [cle_pkg::CHAR_W-1:0]   i_right_rdata,
    output cle_pkg::t_ram_req            o_left_req,
    output cle_pkg::t_ram_req            o_right_req,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output cle_pkg::t_result             o_res
);

    localparam int A = cle_pkg::ADDR_W;
    localparam int C = cle_pkg::CNT_W;
    localparam logic [C-1:0] DEPTH_C = C'(cle_pkg::LINE_DEPTH);

    cle_pkg::t_state r_state, n_state;
    logic [C-1:0]    r_lc, n_lc;
    logic [C-1:0]    r_rc, n_rc;
    logic            r_ovf, n_ovf;
    logic [C-1:0]    r_idx, n_idx;
    logic            r_sel_right, n_sel_right;

    logic [C-1:0] total;
    logic [C-1:0] lc_m1;
    logic [C-1:0] rc_m1;
    logic [C-1:0] idx_p1;
    logic         walk_rd;
    logic [C-1:0] rd_idx;
    logic         rd_right;
    logic [C-1:0] rd_rev;

    assign total  = r_lc + r_rc;
    assign lc_m1  = r_lc - 1'b1;
    assign rc_m1  = r_rc - 1'b1;
    assign idx_p1 = r_idx + 1'b1;

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cle_pkg::ST_IDLE;
            r_lc    <= '0;
            r_rc    <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_lc    <= n_lc;
            r_rc    <= n_rc;
            r_ovf   <= n_ovf;
        end
    end

    // Walk position and source of the pending read
    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_sel_right <= n_sel_right;
    end

    // Next state, memory requests and result
    always_comb begin
        n_state     = r_state;
        n_lc        = r_lc;
        n_rc        = r_rc;
        n_ovf       = r_ovf;
        n_idx       = r_idx;
        n_sel_right = r_sel_right;
        o_left_req  = '0;
        o_right_req = '0;
        o_res_valid = 1'b0;
        o_res       = '0;
        i_key.ready = 1'b0;
        walk_rd     = 1'b0;
        rd_idx      = '0;

        unique case (r_state)
            cle_pkg::ST_IDLE: begin
                i_key.ready = 1'b1;
                if (i_key.valid) begin
                    if (!i_key.func) begin
                        unique case (i_key.key_code)
                            cle_pkg::KEY_LEFT: begin
                                // fetch top of left stack
                                if (r_lc != '0 && r_rc < DEPTH_C) begin
                                    o_left_req.re    = 1'b1;
                                    o_left_req.raddr = lc_m1[A-1:0];
                                    n_state          = cle_pkg::ST_MOVE_L;
                                end
                            end
                            cle_pkg::KEY_RIGHT: begin
                                // fetch top of right stack
                                if (r_rc != '0 && r_lc < DEPTH_C) begin
                                    o_right_req.re    = 1'b1;
                                    o_right_req.raddr = rc_m1[A-1:0];
                                    n_state           = cle_pkg::ST_MOVE_R;
                                end
                            end
                            cle_pkg::KEY_DEL: begin
                                if (r_lc != '0) begin
                                    n_lc = lc_m1;
                                end
                            end
                            default: begin
                                // push at the cursor, or drop when full
                                if (total < DEPTH_C) begin
                                    o_left_req.we    = 1'b1;
                                    o_left_req.waddr = r_lc[A-1:0];
                                    o_left_req.wdata = i_key.key_code;
                                    n_lc             = r_lc + 1'b1;
                                end else begin
                                    n_ovf = 1'b1;
                                end
                            end
                        endcase
                    end else if (total == '0) begin
                        n_state = cle_pkg::ST_EMPTY;
                    end else begin
                        walk_rd = 1'b1;
                        rd_idx  = '0;
                        n_idx   = '0;
                        n_state = cle_pkg::ST_WALK;
                    end
                end
            end
            cle_pkg::ST_MOVE_L: begin
                o_right_req.we    = 1'b1;
                o_right_req.waddr = r_rc[A-1:0];
                o_right_req.wdata = i_left_rdata;
                n_rc              = r_rc + 1'b1;
                n_lc              = lc_m1;
                n_state           = cle_pkg::ST_IDLE;
            end
            cle_pkg::ST_MOVE_R: begin
                o_left_req.we    = 1'b1;
                o_left_req.waddr = r_lc[A-1:0];
                o_left_req.wdata = i_right_rdata;
                n_lc             = r_lc + 1'b1;
                n_rc             = rc_m1;
                n_state          = cle_pkg::ST_IDLE;
            end
            cle_pkg::ST_WALK: begin
                o_res_valid      = 1'b1;
                o_res.out_char   = r_sel_right ? i_right_rdata : i_left_rdata;
                o_res.last_char  = (idx_p1 == total);
                o_res.line_empty = 1'b0;
                o_res.overflowed = r_ovf;
                if (i_res_ready) begin
                    if (idx_p1 == total) begin
                        // line done: clear both stacks
                        n_lc    = '0;
                        n_rc    = '0;
                        n_ovf   = 1'b0;
                        n_state = cle_pkg::ST_IDLE;
                    end else begin
                        walk_rd = 1'b1;
                        rd_idx  = idx_p1;
                        n_idx   = idx_p1;
                    end
                end
            end
            cle_pkg::ST_EMPTY: begin
                o_res_valid      = 1'b1;
                o_res.out_char   = '0;
                o_res.last_char  = 1'b1;
                o_res.line_empty = 1'b1;
                o_res.overflowed = r_ovf;
                if (i_res_ready) begin
                    n_ovf   = 1'b0;
                    n_state = cle_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = cle_pkg::ST_IDLE;
            end
        endcase

        // Walk read: left stack bottom first, then right stack top first
        rd_right = (rd_idx >= r_lc);
        rd_rev   = total - 1'b1 - rd_idx;
        if (walk_rd) begin
            n_sel_right = rd_right;
            if (rd_right) begin
                o_right_req.re    = 1'b1;
                o_right_req.raddr = rd_rev[A-1:0];
            end else begin
                o_left_req.re    = 1'b1;
                o_left_req.raddr = rd_idx[A-1:0];
            end
        end
    end

endmodule

// ===== rtl/cle_checker.sv =====
// Port-level checker for the cursor line editor, bound to the top level.
// Depends on the cursor_line_editor_assert.svh macros.
`include "cursor_line_editor_assert.svh"

module cle_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_func,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_char,
    input logic       i_out_last,
    input logic       i_out_empty,
    input logic       i_out_ovf
);

    logic [10:0] out_bus;
    logic        out_stall;
    logic        out_empty;
    logic        in_finish;

    // Collect the result payload and the handshake conditions
    assign out_bus   = {i_out_char, i_out_last, i_out_empty, i_out_ovf};
    assign out_stall = i_out_valid && !i_out_ready;
    assign out_empty = i_out_valid && i_out_empty;
    assign in_finish = i_in_valid && i_in_ready && i_in_func;

    // Hold a stalled result
    `CLE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(out_bus))

    // An empty line is a single zero character marked last
    `CLE_ASSERT_IMP(a_empty_form, i_clk, i_rst_n, out_empty, i_out_last && i_out_char == 8'h00)

    // Block keystrokes while a line is still being walked out
    `CLE_ASSERT_IMP(a_walk_blocks, i_clk, i_rst_n, i_out_valid && !i_out_last, !i_in_ready)

    // A finish transfer starts the emit sequence
    `CLE_ASSERT_NXT(a_finish_busy, i_clk, i_rst_n, in_finish, !i_in_ready)

endmodule

bind cursor_line_editor cle_checker u_cle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_key.valid),
    .i_in_ready  (i_key.ready),
    .i_in_func   (i_key.func),
    .i_out_valid (o_line.valid),
    .i_out_ready (o_line.ready),
    .i_out_char  (o_line.out_char),
    .i_out_last  (o_line.last_char),
    .i_out_empty (o_line.line_empty),
    .i_out_ovf   (o_line.overflowed)
);
